// ===== design/afrf_pkg.sv =====
package afrf_pkg;

  localparam int CAP_W    = 11;
  localparam int CHCFG_W  = 4;
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam int REG_IDX_W = 1;

  localparam int FRAME_DEPTH_DEF  = 1024;
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int SAMPLE_BITS_DEF  = 32;

  localparam logic [CAP_W-1:0]   CAP_RST = CAP_W'(1024);
  localparam logic [CHCFG_W-1:0] CH_RST  = CHCFG_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CAPACITY = 1'b0,
    REG_CHANNELS = 1'b1
  } reg_idx_t;

endpackage

// ===== design/audio_frame_ring_fifo.sv =====
// Frame FIFO of interleaved audio samples, one sample access per item.
// The result is valid in the cycle after the item is accepted (store read
// data registered at acceptance). One item per cycle is accepted unless
// an output stall holds the input off.
// Reset (rst, synchronous): pointers, channel positions and frame count
// cleared, capacity 1024, channels 2; sample store contents not reset.
module audio_frame_ring_fifo
  import afrf_pkg::*;
#(
  parameter int FRAME_DEPTH  = FRAME_DEPTH_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [OP_W-1:0]        opcode,
  input  logic [SAMPLE_BITS-1:0] sample_in,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   accepted,
  output logic [SAMPLE_BITS-1:0] sample_out,
  output logic                   frame_done,
  output logic [CAP_W-1:0]       readable_frames,
  output logic [CAP_W-1:0]       writable_frames
);

  localparam int FW          = $clog2(FRAME_DEPTH);
  localparam int CW          = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ECH_W       = $clog2(MAX_CHANNELS + 1);
  localparam int STORE_WORDS = FRAME_DEPTH * MAX_CHANNELS;
  localparam int AW          = $clog2(STORE_WORDS);

  logic [CAP_W-1:0]   cap_cfg;
  logic [CHCFG_W-1:0] ch_cfg;
  logic [CAP_W-1:0]   cap_eff;
  logic [ECH_W-1:0]   ch_eff;

  logic [FW-1:0]      write_frame, write_frame_next;
  logic [FW-1:0]      read_frame, read_frame_next;
  logic [CW-1:0]      write_channel, write_channel_next;
  logic [CW-1:0]      read_channel, read_channel_next;
  logic [CAP_W-1:0]   frames_held, frames_held_next;

  logic               cfg_wr;
  logic               accept;
  logic               wr_go, rd_go, done_c, clear_c;
  logic [AW-1:0]      waddr, raddr;

  logic               acc_q, done_q, rd_q;
  logic [CAP_W-1:0]   readable_q, writable_q;
  logic [SAMPLE_BITS-1:0] rd_data;

  logic [SAMPLE_BITS-1:0] store [STORE_WORDS];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_CAPACITY: prdata = DATA_W'(cap_cfg);
      REG_CHANNELS: prdata = DATA_W'(ch_cfg);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_cfg <= CAP_RST;
      ch_cfg  <= CH_RST;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[2]))
        REG_CAPACITY: cap_cfg <= pwdata[CAP_W-1:0];
        REG_CHANNELS: ch_cfg  <= pwdata[CHCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cap_cfg == '0) begin
      cap_eff = CAP_W'(1);
    end else if (int'(cap_cfg) > FRAME_DEPTH) begin
      cap_eff = CAP_W'(FRAME_DEPTH);
    end else begin
      cap_eff = cap_cfg;
    end
    if (ch_cfg == '0) begin
      ch_eff = ECH_W'(1);
    end else if (int'(ch_cfg) > MAX_CHANNELS) begin
      ch_eff = ECH_W'(MAX_CHANNELS);
    end else begin
      ch_eff = ECH_W'(ch_cfg);
    end
  end

  // handshake
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign waddr = AW'(AW'(write_frame) * AW'(MAX_CHANNELS) + AW'(write_channel));
  assign raddr = AW'(AW'(read_frame) * AW'(MAX_CHANNELS) + AW'(read_channel));

  always_comb begin
    write_frame_next   = write_frame;
    read_frame_next    = read_frame;
    write_channel_next = write_channel;
    read_channel_next  = read_channel;
    frames_held_next   = frames_held;
    wr_go   = 1'b0;
    rd_go   = 1'b0;
    done_c  = 1'b0;
    clear_c = 1'b0;
    case (op_t'(opcode))
      OP_WRITE: begin
        wr_go = (write_channel != '0) || (frames_held < cap_eff);
        if (wr_go) begin
          if (32'(write_channel) + 32'd1 >= 32'(ch_eff)) begin
            write_channel_next = '0;
            write_frame_next   = (32'(write_frame) + 32'd1 >= 32'(cap_eff)) ?
                                 '0 : FW'(write_frame + 1'b1);
            frames_held_next   = frames_held + 1'b1;
            done_c             = 1'b1;
          end else begin
            write_channel_next = CW'(write_channel + 1'b1);
          end
        end
      end
      OP_READ: begin
        rd_go = (read_channel != '0) || (frames_held != '0);
        if (rd_go) begin
          if (32'(read_channel) + 32'd1 >= 32'(ch_eff)) begin
            read_channel_next = '0;
            read_frame_next   = (32'(read_frame) + 32'd1 >= 32'(cap_eff)) ?
                                '0 : FW'(read_frame + 1'b1);
            if (frames_held != '0) frames_held_next = frames_held - 1'b1;
            done_c            = 1'b1;
          end else begin
            read_channel_next = CW'(read_channel + 1'b1);
          end
        end
      end
      OP_CLEAR: begin
        clear_c            = 1'b1;
        write_frame_next   = '0;
        read_frame_next    = '0;
        write_channel_next = '0;
        read_channel_next  = '0;
        frames_held_next   = '0;
      end
      default: ;
    endcase
    if (frames_held_next > cap_eff) frames_held_next = cap_eff;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      write_frame   <= '0;
      read_frame    <= '0;
      write_channel <= '0;
      read_channel  <= '0;
      frames_held   <= '0;
    end else if (accept) begin
      write_frame   <= write_frame_next;
      read_frame    <= read_frame_next;
      write_channel <= write_channel_next;
      read_channel  <= read_channel_next;
      frames_held   <= frames_held_next;
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (accept && wr_go) store[waddr] <= sample_in;
    if (accept && rd_go) rd_data <= store[raddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_q      <= wr_go | rd_go;
      done_q     <= done_c;
      rd_q       <= rd_go;
      readable_q <= frames_held_next;
      writable_q <= cap_eff - frames_held_next;
    end
  end

  assign accepted        = acc_q;
  assign frame_done      = done_q;
  assign sample_out      = rd_q ? rd_data : '0;
  assign readable_frames = readable_q;
  assign writable_frames = writable_q;

`ifndef ASSERT_OFF
  a_held_le_cap: assert property (@(posedge clk) disable iff (rst)
    frames_held <= cap_eff)
    else $error("frame count above capacity");

  a_done_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> accepted)
    else $error("frame done without an accepted access");

  a_sample_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> sample_out == '0)
    else $error("sample shown on a refused item");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && clear_c && !cfg_wr |=> frames_held == '0 && write_channel == '0)
    else $error("clear left state behind");
`endif

endmodule
